// File: hdl/ptar_pkg.sv
package ptar_pkg;

  // queue geometry
  localparam int QueueDepth = 64;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int SlotW      = 7;
  localparam int CntW       = 6;

  // fifo word layout
  localparam int WordBits = 24;
  localparam int DataBits = 19;
  localparam int TagBits  = 5;
  localparam int ChanBits = 19;
  localparam int SampleW  = 3 * ChanBits;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] RegRouteMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegShiftCh1    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegShiftCh2    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShiftCh3    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegQueueSlots  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegQueueEnable = 3'd5;

  // item kinds
  localparam logic [1:0] KindWord  = 2'd0;
  localparam logic [1:0] KindPop   = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  // route modes
  localparam logic [1:0] RouteRed = 2'd1;
  localparam logic [1:0] RouteIr  = 2'd2;

  // tags of a triple
  localparam logic [TagBits-1:0] TagFirst  = 5'd1;
  localparam logic [TagBits-1:0] TagSecond = 5'd2;
  localparam logic [TagBits-1:0] TagThird  = 5'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic word_op;
    logic clear_op;
    logic nop_op;
    logic empty_op;
    logic pop_issue;
    logic pop_finish;
  } ptar_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic count_zero;
  } ptar_status_t;

endpackage

// File: hdl/ptar_ctrl.sv
module ptar_ctrl import ptar_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic [1:0]   kind_i,
  input  ptar_status_t status_i,
  output ptar_cmd_t    cmd_o,
  output logic         busy
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StPop  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          unique case (kind_i)
            KindWord:  cmd_o.word_op = 1'b1;
            KindPop: begin
              if (status_i.count_zero) begin
                cmd_o.empty_op = 1'b1;
              end else begin
                cmd_o.pop_issue = 1'b1;
                state_d         = StPop;
              end
            end
            KindClear: cmd_o.clear_op = 1'b1;
            default:   cmd_o.nop_op = 1'b1;
          endcase
        end
      end
      StPop: begin
        busy             = 1'b1;
        cmd_o.pop_finish = 1'b1;
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/ptar_datapath.sv
module ptar_datapath import ptar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptar_cmd_t           cmd_i,
  output ptar_status_t        status_o,
  input  logic [WordBits-1:0] fifo_word_i,
  input  logic                burst_start_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output logic                pop_valid_o,
  output logic [ChanBits-1:0] ppg_one_o,
  output logic [ChanBits-1:0] ppg_two_o,
  output logic [ChanBits-1:0] ppg_three_o,
  output logic                queue_empty_o,
  output logic                pushed_o,
  output logic                dropped_oldest_o,
  output logic [CntW-1:0]     stored_count_o
);

  // configuration registers
  logic [1:0]       route_q;
  logic [4:0]       sh1_q, sh2_q, sh3_q;
  logic [SlotW-1:0] slots_q;
  logic             qen_q;

  // deframer and queue state
  logic [ChanBits-1:0] ch1_q, ch2_q, ch3_q, ch1_d, ch2_d, ch3_d;
  logic                started_q, started_d, compl_q, compl_d;
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SampleW-1:0]  mem_q [QueueDepth];
  logic [SampleW-1:0]  rd_data_q;

  // result registers
  logic                done_q, pop_valid_q, empty_q, pushed_q, dropped_q;
  logic [ChanBits-1:0] res1_q, res2_q, res3_q;
  logic [CntW-1:0]     rcnt_q;

  logic [SlotW-1:0]    slots_use;
  logic [DataBits-1:0] val;
  logic [TagBits-1:0]  tag;
  logic                tag_ok, started0, compl0, push, drop;
  logic [1:0]          chan;
  logic [PtrW-1:0]     wnext, rnext;
  logic                cfg_q_write;

  // clamp slot count to the queue range
  always_comb begin
    priority if (slots_q < SlotW'(2)) begin
      slots_use = SlotW'(2);
    end else if (slots_q > SlotW'(QueueDepth)) begin
      slots_use = SlotW'(QueueDepth);
    end else begin
      slots_use = slots_q;
    end
  end

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p,
                                               input logic [SlotW-1:0] s);
    logic [SlotW-1:0] inc;
    inc = SlotW'(p) + SlotW'(1);
    next_ptr = (inc >= s) ? '0 : inc[PtrW-1:0];
  endfunction

  assign val = fifo_word_i[DataBits-1:0];
  assign tag = fifo_word_i[DataBits +: TagBits];
  assign tag_ok = (tag == TagFirst) || (tag == TagSecond) || (tag == TagThird);

  // tag to channel mapping, 1..3
  always_comb begin
    priority if (route_q == RouteRed) begin
      chan = (tag == TagFirst) ? 2'd3 : (tag == TagSecond) ? 2'd2 : 2'd1;
    end else if (route_q == RouteIr) begin
      chan = (tag == TagFirst) ? 2'd2 : (tag == TagSecond) ? 2'd1 : 2'd3;
    end else begin
      chan = tag[1:0];
    end
  end

  // deframing of one fifo word
  always_comb begin
    started0 = burst_start_i ? 1'b0 : started_q;
    compl0   = burst_start_i ? 1'b0 : compl_q;
    ch1_d    = ch1_q;
    ch2_d    = ch2_q;
    ch3_d    = ch3_q;
    started_d = started0;
    compl_d   = compl0;
    if (tag_ok) begin
      priority if (chan == 2'd1) begin
        ch1_d = val >> sh1_q;
      end else if (chan == 2'd2) begin
        ch2_d = val >> sh2_q;
      end else begin
        ch3_d = val >> sh3_q;
      end
      if (tag == TagFirst) begin
        started_d = 1'b1;
      end
      if (tag == TagThird && started0) begin
        compl_d = 1'b1;
      end
    end
    push = compl_d && started_d && qen_q;
    if (push) begin
      started_d = 1'b0;
      compl_d   = 1'b0;
    end
  end

  // queue pointers and count
  assign wnext = next_ptr(wptr_q, slots_use);
  assign rnext = next_ptr(rptr_q, slots_use);
  assign drop  = (rptr_q == wnext);
  assign cfg_q_write = cfg_we_i &&
                       ((cfg_idx_i == RegQueueSlots) || (cfg_idx_i == RegQueueEnable));

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    priority if (cfg_q_write || cmd_i.clear_op) begin
      wptr_d = '0;
      rptr_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.word_op && push) begin
      wptr_d = wnext;
      if (drop) begin
        rptr_d = rnext;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (cmd_i.pop_issue) begin
      rptr_d = rnext;
      cnt_d  = cnt_q - CntW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign status_o.count_zero = (cnt_q == '0);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_q <= '0;
      sh1_q   <= '0;
      sh2_q   <= '0;
      sh3_q   <= '0;
      slots_q <= SlotW'(QueueDepth);
      qen_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRouteMode:   route_q <= cfg_data_i[1:0];
        RegShiftCh1:    sh1_q   <= cfg_data_i[4:0];
        RegShiftCh2:    sh2_q   <= cfg_data_i[4:0];
        RegShiftCh3:    sh3_q   <= cfg_data_i[4:0];
        RegQueueSlots:  slots_q <= cfg_data_i[SlotW-1:0];
        RegQueueEnable: qen_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // channel registers, flags and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch1_q     <= '0;
      ch2_q     <= '0;
      ch3_q     <= '0;
      started_q <= 1'b0;
      compl_q   <= 1'b0;
      wptr_q    <= '0;
      rptr_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.word_op) begin
        ch1_q     <= ch1_d;
        ch2_q     <= ch2_d;
        ch3_q     <= ch3_d;
        started_q <= started_d;
        compl_q   <= compl_d;
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.word_op && push) begin
      mem_q[wptr_q] <= {ch3_d, ch2_d, ch1_d};
    end
    if (cmd_i.pop_issue) begin
      rd_data_q <= mem_q[rptr_q];
    end
  end

  // result word strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.word_op || cmd_i.clear_op || cmd_i.nop_op ||
                cmd_i.empty_op || cmd_i.pop_finish;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_finish) begin
      pop_valid_q <= 1'b1;
      res1_q      <= rd_data_q[ChanBits-1:0];
      res2_q      <= rd_data_q[ChanBits +: ChanBits];
      res3_q      <= rd_data_q[2*ChanBits +: ChanBits];
      empty_q     <= 1'b0;
      pushed_q    <= 1'b0;
      dropped_q   <= 1'b0;
      rcnt_q      <= cnt_q;
    end else begin
      pop_valid_q <= 1'b0;
      res1_q      <= '0;
      res2_q      <= '0;
      res3_q      <= '0;
      empty_q     <= cmd_i.empty_op;
      pushed_q    <= cmd_i.word_op && push;
      dropped_q   <= cmd_i.word_op && push && drop;
      rcnt_q      <= cnt_d;
    end
  end

  assign done_o           = done_q;
  assign pop_valid_o      = pop_valid_q;
  assign ppg_one_o        = res1_q;
  assign ppg_two_o        = res2_q;
  assign ppg_three_o      = res3_q;
  assign queue_empty_o    = empty_q;
  assign pushed_o         = pushed_q;
  assign dropped_oldest_o = dropped_q;
  assign stored_count_o   = rcnt_q;

endmodule

// File: hdl/ppg_tag_assembler_ring_queue_unit.sv
// results: a fifo word, clear, empty pop or unknown kind gives its result word
//   with done_o in the cycle after it is taken; a pop of a stored sample is read
//   through the memory's registered read port, then the result registers
// throughput: one item per cycle; busy stalls new items while a stored pop finishes
// reset: config registers, flags, channel values, pointers and count clear, slots to 64;
//   memory and result payload are not cleared; results cannot be stalled by the receiver
module ppg_tag_assembler_ring_queue_unit import ptar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic [WordBits-1:0] fifo_word_i,
  input  logic                burst_start_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output logic                pop_valid_o,
  output logic [ChanBits-1:0] ppg_one_o,
  output logic [ChanBits-1:0] ppg_two_o,
  output logic [ChanBits-1:0] ppg_three_o,
  output logic                queue_empty_o,
  output logic                pushed_o,
  output logic                dropped_oldest_o,
  output logic [CntW-1:0]     stored_count_o
);

  ptar_cmd_t    cmd;
  ptar_status_t status;

  // sequencer
  ptar_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // deframer, ring queue and result registers
  ptar_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .fifo_word_i      (fifo_word_i),
    .burst_start_i    (burst_start_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .pop_valid_o      (pop_valid_o),
    .ppg_one_o        (ppg_one_o),
    .ppg_two_o        (ppg_two_o),
    .ppg_three_o      (ppg_three_o),
    .queue_empty_o    (queue_empty_o),
    .pushed_o         (pushed_o),
    .dropped_oldest_o (dropped_oldest_o),
    .stored_count_o   (stored_count_o)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ptar_pkg::*;

  // register index with no register behind it
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd6;

  // item kind with no operation behind it
  localparam logic [1:0] KindSpare = 2'd3;

  typedef enum logic [1:0] {ChanNone, ChanOne, ChanTwo, ChanThree} chan_sel_e;

  typedef struct packed {
    logic                pop_valid;
    logic [ChanBits-1:0] one;
    logic [ChanBits-1:0] two;
    logic [ChanBits-1:0] three;
    logic                empty;
    logic                pushed;
    logic                dropped;
    logic [CntW-1:0]     count;
  } sample_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          kind_i;
  logic [WordBits-1:0] fifo_word_i;
  logic                burst_start_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                done_o;
  logic                pop_valid_o;
  logic [ChanBits-1:0] ppg_one_o;
  logic [ChanBits-1:0] ppg_two_o;
  logic [ChanBits-1:0] ppg_three_o;
  logic                queue_empty_o;
  logic                pushed_o;
  logic                dropped_oldest_o;
  logic [CntW-1:0]     stored_count_o;

  ppg_tag_assembler_ring_queue_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the block: registers, channel values, triple flags, ring queue
  logic [1:0]          route_sh;
  logic [4:0]          shift_sh [1:3];
  logic [SlotW-1:0]    slots_sh;
  logic                enable_sh;
  logic [ChanBits-1:0] chan_sh [1:3];
  logic                started_sh;
  logic                completed_sh;
  logic [SampleW-1:0]  sample_mem [QueueDepth];
  int                  wr_slot;
  int                  rd_slot;
  int                  held;

  sample_word_t expected_words [$];
  int           errs;
  int           burst_left;
  bit           idle_on;

  function automatic int slots_used();
    if (slots_sh < 2) return 2;
    if (slots_sh > QueueDepth) return QueueDepth;
    return slots_sh;
  endfunction

  function automatic int next_slot(input int p);
    return (p + 1 >= slots_used()) ? 0 : p + 1;
  endfunction

  function automatic logic [ChanBits-1:0] rand_val();
    return ChanBits'($urandom_range(0, (1 << DataBits) - 1));
  endfunction

  task automatic flush_queue();
    wr_slot = 0;
    rd_slot = 0;
    held    = 0;
  endtask

  task automatic shadow_reset();
    route_sh     = '0;
    shift_sh[1]  = '0;
    shift_sh[2]  = '0;
    shift_sh[3]  = '0;
    slots_sh     = 7'd64;
    enable_sh    = 1'b0;
    chan_sh[1]   = '0;
    chan_sh[2]   = '0;
    chan_sh[3]   = '0;
    started_sh   = 1'b0;
    completed_sh = 1'b0;
    flush_queue();
  endtask

  // work out the result word of one accepted item
  task automatic predict_sample(input logic [1:0] kind, input logic [WordBits-1:0] word,
                                input logic burst);
    sample_word_t        res;
    logic [TagBits-1:0]  tag;
    logic [DataBits-1:0] val;
    chan_sel_e           ch;
    logic [SampleW-1:0]  s;
    res = '0;
    tag = word[WordBits-1 -: TagBits];
    val = word[DataBits-1:0];
    ch  = ChanNone;
    if (kind == KindWord) begin
      if (burst) begin
        started_sh   = 1'b0;
        completed_sh = 1'b0;
      end
      if (tag == TagFirst || tag == TagSecond || tag == TagThird) begin
        if (route_sh == RouteRed)
          ch = (tag == TagFirst) ? ChanThree : (tag == TagSecond) ? ChanTwo : ChanOne;
        else if (route_sh == RouteIr)
          ch = (tag == TagFirst) ? ChanTwo : (tag == TagSecond) ? ChanOne : ChanThree;
        else
          ch = (tag == TagFirst) ? ChanOne : (tag == TagSecond) ? ChanTwo : ChanThree;
        chan_sh[ch] = ChanBits'(val >> shift_sh[ch]);
        if (tag == TagFirst) started_sh = 1'b1;
        if (tag == TagThird && started_sh) completed_sh = 1'b1;
      end
      if (completed_sh && started_sh && enable_sh) begin
        sample_mem[wr_slot] = {chan_sh[3], chan_sh[2], chan_sh[1]};
        wr_slot = next_slot(wr_slot);
        held++;
        if (rd_slot == wr_slot) begin
          rd_slot = next_slot(rd_slot);
          held--;
          res.dropped = 1'b1;
        end
        res.pushed   = 1'b1;
        started_sh   = 1'b0;
        completed_sh = 1'b0;
      end
    end else if (kind == KindPop) begin
      if (held == 0) begin
        res.empty = 1'b1;
      end else begin
        s = sample_mem[rd_slot];
        res.one   = s[ChanBits-1:0];
        res.two   = s[2*ChanBits-1:ChanBits];
        res.three = s[3*ChanBits-1:2*ChanBits];
        rd_slot   = next_slot(rd_slot);
        held--;
        res.pop_valid = 1'b1;
      end
    end else if (kind == KindClear) begin
      flush_queue();
    end
    res.count = CntW'(held);
    expected_words.push_back(res);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    unique case (idx)
      RegRouteMode:   route_sh = data[1:0];
      RegShiftCh1:    shift_sh[1] = data[4:0];
      RegShiftCh2:    shift_sh[2] = data[4:0];
      RegShiftCh3:    shift_sh[3] = data[4:0];
      RegQueueSlots: begin
        slots_sh = data;
        flush_queue();
      end
      RegQueueEnable: begin
        enable_sh = data[0];
        flush_queue();
      end
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup_regs(input logic [CfgDataW-1:0] route, sh1, sh2, sh3, slots, en);
    write_reg(RegRouteMode, route);
    write_reg(RegShiftCh1, sh1);
    write_reg(RegShiftCh2, sh2);
    write_reg(RegShiftCh3, sh3);
    write_reg(RegQueueSlots, slots);
    write_reg(RegQueueEnable, en);
  endtask

  // send one item, with random gaps between bursts of items while idle_on is set
  task automatic send_item(input logic [1:0] kind, input logic [WordBits-1:0] word,
                           input logic burst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start         <= 1'b1;
    kind_i        <= kind;
    fifo_word_i   <= word;
    burst_start_i <= burst;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    predict_sample(kind, word, burst);
  endtask

  task automatic send_fifo(input logic [TagBits-1:0] tag, input logic [ChanBits-1:0] val,
                           input logic burst);
    send_item(KindWord, {tag, val}, burst);
  endtask

  // let every outstanding word arrive, then the block settle
  task automatic drain();
    start      <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  // compare each result word with the oldest prediction
  always @(negedge clk_i) begin
    sample_word_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errs++;
      end else begin
        want = expected_words.pop_front();
        check_field("pop_valid", want.pop_valid, pop_valid_o);
        check_field("ppg_one", want.one, ppg_one_o);
        check_field("ppg_two", want.two, ppg_two_o);
        check_field("ppg_three", want.three, ppg_three_o);
        check_field("queue_empty", want.empty, queue_empty_o);
        check_field("pushed", want.pushed, pushed_o);
        check_field("dropped_oldest", want.dropped, dropped_oldest_o);
        check_field("stored_count", want.count, stored_count_o);
      end
    end
  end

  // queue disabled after reset: a full triple is held but not pushed
  task automatic test_reset_defaults();
    send_fifo(TagFirst, '1, 1'b1);
    send_fifo(TagSecond, '0, 1'b0);
    send_fifo(TagThird, 19'h2AAAA, 1'b0);
    send_item(KindPop, '0, 1'b0);
    drain();
  endtask

  // pushes, drops, pops, clear and odd words on a two slot queue
  task automatic test_queue_ops();
    setup_regs(7'd0, 7'd0, 7'd0, 7'd0, 7'd2, 7'd1);
    // flags left over from the disabled triple push on the next word
    send_fifo(5'd0, '1, 1'b0);
    send_fifo(TagFirst, '1, 1'b0);
    send_fifo(TagSecond, '1, 1'b0);
    send_fifo(TagThird, '1, 1'b0);
    send_item(KindPop, '0, 1'b0);
    send_item(KindPop, '0, 1'b1);
    // third tag without a first one after a burst start
    send_fifo(TagThird, 19'h12345, 1'b1);
    send_fifo(5'd31, '1, 1'b1);
    send_item(KindClear, '1, 1'b1);
    send_item(KindSpare, '1, 1'b1);
    drain();
  endtask

  // red and infrared mapping, mode three, shift extremes, slot clamp
  task automatic test_route_extremes();
    setup_regs(7'h7F, 7'd18, 7'h7F, 7'd18, 7'd0, 7'h7F);
    write_reg(RegSpare, 7'h55);
    send_fifo(TagFirst, '1, 1'b1);
    send_fifo(TagSecond, '1, 1'b0);
    send_fifo(TagThird, '1, 1'b0);
    send_item(KindPop, '0, 1'b0);
    drain();
    write_reg(RegRouteMode, {5'd0, RouteRed});
    send_fifo(TagFirst, '1, 1'b1);
    send_fifo(TagSecond, 19'h40000, 1'b0);
    send_fifo(TagThird, 19'h7FFFE, 1'b0);
    send_item(KindPop, '0, 1'b0);
    drain();
    setup_regs({5'd0, RouteIr}, 7'd0, 7'd0, 7'd0, 7'd127, 7'd1);
    send_fifo(TagFirst, 19'h00001, 1'b1);
    send_fifo(TagSecond, 19'h55555, 1'b0);
    send_fifo(TagThird, 19'h2AAAA, 1'b0);
    send_item(KindPop, '0, 1'b0);
    drain();
  endtask

  // mostly well-formed triples with random content, plus pops and noise
  task automatic test_random_phase(input int n_items);
    int sent;
    int pick;
    int pops;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        send_fifo(TagFirst, rand_val(), 1'($urandom_range(0, 1)));
        send_fifo(TagSecond, rand_val(), 1'($urandom_range(0, 7) == 0));
        send_fifo(TagThird, rand_val(), 1'($urandom_range(0, 9) == 0));
        sent += 3;
      end else if (pick < 16) begin
        pops = $urandom_range(1, 3);
        repeat (pops) send_item(KindPop, WordBits'($urandom), 1'($urandom_range(0, 1)));
        sent += pops;
      end else if (pick < 19) begin
        send_item(KindWord, WordBits'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_item(($urandom_range(0, 1) == 0) ? KindClear : KindSpare, WordBits'($urandom),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_random();
    logic [CfgDataW-1:0] slots;
    logic [CfgDataW-1:0] shifts [1:3];
    int sel;
    for (int phase = 0; phase < 8; phase++) begin
      for (int c = 1; c <= 3; c++) begin
        sel = $urandom_range(0, 4);
        shifts[c] = (sel == 0) ? 7'd18 : (sel == 1) ? 7'h7F : (sel == 2) ? 7'd0 :
                    CfgDataW'($urandom_range(0, 31));
      end
      sel = $urandom_range(0, 7);
      slots = (sel == 0) ? 7'd64 : (sel == 1) ? CfgDataW'($urandom_range(0, 1)) :
              (sel == 2) ? CfgDataW'($urandom_range(65, 127)) :
              CfgDataW'($urandom_range(2, 9));
      setup_regs(CfgDataW'($urandom_range(0, 3)), shifts[1], shifts[2], shifts[3], slots,
                 (phase == 3) ? 7'd0 : CfgDataW'(1 + 2 * $urandom_range(0, 63)));
      idle_on = (phase % 3 != 2);
      test_random_phase(56);
    end
  endtask

  initial begin
    errs          = 0;
    burst_left    = 0;
    idle_on       = 1'b1;
    rst_ni        = 1'b0;
    start         <= 1'b0;
    kind_i        <= KindWord;
    fifo_word_i   <= '0;
    burst_start_i <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegRouteMode;
    cfg_data_i    <= '0;
    shadow_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_queue_ops();
    test_route_extremes();
    test_random();
    drain();

    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      errs++;
    end
    if (errs == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
hdl/ptar_pkg.sv
hdl/ptar_ctrl.sv
hdl/ptar_datapath.sv
hdl/ppg_tag_assembler_ring_queue_unit.sv
bench/tb.sv
